[sv/sajf_pkg.sv]
`default_nettype none

package sajf_pkg;

   localparam int STORE_DEPTH   = 8192;
   localparam int MAX_TAKE      = 64;
   localparam int QUEUE_DEPTH   = 4;

   localparam int SAMPLE_W      = 32;
   localparam int FRAME_W       = 2 * SAMPLE_W;
   localparam int TOTAL_W       = 32;
   localparam int FRAME_COUNT_W = 7;
   localparam int CFG_W         = 14;
   localparam int CSR_IDX_W     = 4;
   localparam int CSR_DATA_W    = 32;

   localparam int PTR_W   = $clog2(STORE_DEPTH);
   localparam int FILL_W  = $clog2(STORE_DEPTH + 1);
   localparam int DROP_W  = FILL_W + 1;
   localparam int COUNT_W = $clog2(MAX_TAKE + 1);
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(4800);
   localparam logic [CFG_W-1:0] RESERVE_RESET  = CFG_W'(960);

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVE  = CSR_IDX_W'(1);

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_TAKE = 1'b1
   } op_type;

   typedef enum logic {
      BK_IDLE,
      BK_TAKE
   } back_state_type;

   typedef struct packed {
      op_type                     op;
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic [COUNT_W-1:0]         count;
   } cmd_type;

   typedef struct packed {
      logic [CFG_W-1:0] capacity;
      logic [CFG_W-1:0] reserve;
   } cfg_type;

   typedef struct packed {
      logic               silent;
      logic               underrun;
      logic               last;
      logic [TOTAL_W-1:0] overflow_total;
      logic [TOTAL_W-1:0] underrun_total;
   } frame_meta_type;

endpackage

`default_nettype wire

[sv/sajf_ifs.sv]
`default_nettype none

interface sajf_req_if;
   import sajf_pkg::*;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic signed [SAMPLE_W-1:0]    left_sample;
   logic signed [SAMPLE_W-1:0]    right_sample;
   logic [FRAME_COUNT_W-1:0]      frame_count;

   modport source (output valid, op, left_sample, right_sample, frame_count, input ready);
   modport sink (input valid, op, left_sample, right_sample, frame_count, output ready);
   modport monitor (input valid, ready, op, left_sample, right_sample, frame_count);
endinterface

interface sajf_rsp_if;
   import sajf_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_W-1:0]    left_out;
   logic signed [SAMPLE_W-1:0]    right_out;
   logic                          silent;
   logic                          underrun_now;
   logic                          last_frame;
   logic [TOTAL_W-1:0]            overflow_total;
   logic [TOTAL_W-1:0]            underrun_total;

   modport source (output valid, left_out, right_out, silent, underrun_now, last_frame,
                   overflow_total, underrun_total, input ready);
   modport sink (input valid, left_out, right_out, silent, underrun_now, last_frame,
                 overflow_total, underrun_total, output ready);
   modport monitor (input valid, ready, left_out, right_out, silent, underrun_now,
                    last_frame, overflow_total, underrun_total);
endinterface

interface sajf_csr_if;
   import sajf_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_IDX_W-1:0]      index;
   logic [CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/sajf_front.sv]
`default_nettype none

module sajf_front (
   input  logic              clock,
   input  logic              reset,
   sajf_req_if.sink          req,
   output logic              cmd_valid,
   output sajf_pkg::cmd_type cmd,
   input  logic              cmd_pop
);
   import sajf_pkg::*;

   cmd_type             queue_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   head_ff, head_in;
   logic [QPTR_W-1:0]   tail_ff, tail_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             cmd_new;
   logic                push;

   assign req.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_mem[head_ff];

   // decode op, clamp take count
   always_comb begin
      cmd_new.op           = op_type'(req.op);
      cmd_new.left_sample  = req.left_sample;
      cmd_new.right_sample = req.right_sample;
      if (req.frame_count > FRAME_COUNT_W'(MAX_TAKE)) begin
         cmd_new.count = COUNT_W'(MAX_TAKE);
      end else begin
         cmd_new.count = COUNT_W'(req.frame_count);
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = tail_ff + 1'b1;
      end
      if (cmd_pop) begin
         head_in = head_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[tail_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

[sv/sajf_back.sv]
`default_nettype none

module sajf_back (
   input  logic              clock,
   input  logic              reset,
   input  sajf_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   input  sajf_pkg::cmd_type cmd,
   output logic              cmd_pop,
   sajf_rsp_if.source        rsp
);
   import sajf_pkg::*;

   back_state_type        state_ff, state_in;
   logic [PTR_W-1:0]      rp_ff, rp_in;
   logic [PTR_W-1:0]      wp_ff, wp_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic                  primed_ff, primed_in;
   logic [TOTAL_W-1:0]    ovf_ff, ovf_in;
   logic [TOTAL_W-1:0]    und_ff, und_in;
   logic [COUNT_W-1:0]    remaining_ff, remaining_in;
   logic                  silence_ff, silence_in;
   logic                  under_ff, under_in;

   logic [FRAME_W-1:0]    store_mem [STORE_DEPTH];
   logic [FRAME_W-1:0]    rdata_ff;
   logic                  s1_valid_ff;
   frame_meta_type        s1_meta_ff;
   logic                  s2_valid_ff;
   frame_meta_type        s2_meta_ff;
   logic [FRAME_W-1:0]    s2_frame_ff;

   logic                  s1_adv;
   logic                  s1_free;
   logic                  issue;
   logic                  wr_en;

   logic [FILL_W-1:0]     cap_eff;
   logic [FILL_W-1:0]     fill_inc;
   logic [FILL_W-1:0]     fill_new;
   logic [DROP_W-1:0]     drops;
   logic                  take_starve;
   logic                  take_under;

   assign s1_adv  = !s2_valid_ff || rsp.ready;
   assign s1_free = !s1_valid_ff || s1_adv;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && cmd.op == OP_TAKE && cmd.count != '0) begin
               state_in = BK_TAKE;
            end
         end
         BK_TAKE: begin
            if (s1_free && remaining_ff == COUNT_W'(1)) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop = 1'b0;
      issue   = 1'b0;
      unique case (state_ff)
         BK_IDLE: cmd_pop = cmd_valid;
         BK_TAKE: issue = s1_free;
         default: ;
      endcase
   end

   // push: at most one slot freed for a full store, then trim to capacity
   always_comb begin
      if (32'(cfg.capacity) > 32'(STORE_DEPTH)) begin
         cap_eff = FILL_W'(STORE_DEPTH);
      end else begin
         cap_eff = FILL_W'(cfg.capacity);
      end
      if (fill_ff == FILL_W'(STORE_DEPTH)) begin
         fill_inc = fill_ff;
      end else begin
         fill_inc = fill_ff + 1'b1;
      end
      fill_new = (fill_inc > cap_eff) ? cap_eff : fill_inc;
      drops    = DROP_W'(fill_ff) + DROP_W'(1) - DROP_W'(fill_new);
   end

   // take: priming test, then underrun test
   always_comb begin
      take_starve = !primed_ff &&
                    (32'(fill_ff) < 32'(cmd.count) + 32'(cfg.reserve));
      take_under  = !take_starve && (32'(fill_ff) < 32'(cmd.count));
   end

   always_comb begin
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      primed_in    = primed_ff;
      ovf_in       = ovf_ff;
      und_in       = und_ff;
      remaining_in = remaining_ff;
      silence_in   = silence_ff;
      under_in     = under_ff;
      wr_en        = 1'b0;
      if (cmd_pop) begin
         if (cmd.op == OP_PUSH) begin
            wr_en   = 1'b1;
            wp_in   = wp_ff + 1'b1;
            fill_in = fill_new;
            rp_in   = rp_ff + drops[PTR_W-1:0];
            ovf_in  = ovf_ff + TOTAL_W'(drops);
         end else begin
            remaining_in = cmd.count;
            silence_in   = take_starve || take_under;
            under_in     = take_under;
            primed_in    = (primed_ff || !take_starve) && !take_under;
            und_in       = und_ff + TOTAL_W'(take_under);
         end
      end else if (issue) begin
         remaining_in = remaining_ff - 1'b1;
         if (!silence_ff) begin
            rp_in   = rp_ff + 1'b1;
            fill_in = fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         primed_ff    <= 1'b0;
         ovf_ff       <= '0;
         und_ff       <= '0;
         remaining_ff <= '0;
         silence_ff   <= 1'b0;
         under_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         primed_ff    <= primed_in;
         ovf_ff       <= ovf_in;
         und_ff       <= und_in;
         remaining_ff <= remaining_in;
         silence_ff   <= silence_in;
         under_ff     <= under_in;
         if (issue) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wp_ff] <= {cmd.right_sample, cmd.left_sample};
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rdata_ff <= store_mem[rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_meta_ff.silent         <= silence_ff;
         s1_meta_ff.underrun       <= under_ff;
         s1_meta_ff.last           <= (remaining_ff == COUNT_W'(1));
         s1_meta_ff.overflow_total <= ovf_ff;
         s1_meta_ff.underrun_total <= und_ff;
      end
      if (s1_adv && s1_valid_ff) begin
         s2_meta_ff  <= s1_meta_ff;
         s2_frame_ff <= s1_meta_ff.silent ? '0 : rdata_ff;
      end
   end

   assign rsp.valid          = s2_valid_ff;
   assign rsp.left_out       = s2_frame_ff[SAMPLE_W-1:0];
   assign rsp.right_out      = s2_frame_ff[FRAME_W-1:SAMPLE_W];
   assign rsp.silent         = s2_meta_ff.silent;
   assign rsp.underrun_now   = s2_meta_ff.underrun;
   assign rsp.last_frame     = s2_meta_ff.last;
   assign rsp.overflow_total = s2_meta_ff.overflow_total;
   assign rsp.underrun_total = s2_meta_ff.underrun_total;

endmodule

`default_nettype wire

[sv/stereo_audio_fifo_with_priming.sv]
// Stereo audio jitter buffer with priming.
// req_bus: one command per transfer. op 0 pushes one stereo frame, op 1 takes
//   frame_count frames (clamped to 64). Commands wait in a four-entry queue.
// rsp_bus: one transfer per frame of a take, oldest first, or silent filler
//   while not primed or on underrun; last_frame marks the end of a take.
//   A push gives no transfer.
// csr_bus: index 0 capacity in frames, index 1 priming reserve; always ready.
// Flow: from an idle block the first frame of a take passes the command queue,
//   the sequencer, the store read stage and the output stage to rsp_bus. A take
//   holds the sequencer until its last frame is read; sequencer and single store
//   read port give one frame per cycle while the output pipe is not stalled.
// Reset: pointers, fill, priming and both counters clear, capacity returns to
//   4800 and reserve to 960. Frame store contents are not cleared.
// Receiver stall: the two-stage output pipe holds, the sequencer stops
//   reading, the queue fills and req_bus.ready drops once four commands wait.
`default_nettype none

module stereo_audio_fifo_with_priming (
   input  logic       clock,
   input  logic       reset,
   sajf_req_if.sink   req_bus,
   sajf_rsp_if.source rsp_bus,
   sajf_csr_if.sink   csr_bus
);
   import sajf_pkg::*;

   cfg_type          cfg;
   logic [CFG_W-1:0] capacity_ff, capacity_in;
   logic [CFG_W-1:0] reserve_ff, reserve_in;
   logic             cmd_valid;
   cmd_type          cmd;
   logic             cmd_pop;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      capacity_in = capacity_ff;
      reserve_in  = reserve_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_CAPACITY: capacity_in = csr_bus.data[CFG_W-1:0];
            CSR_RESERVE:  reserve_in  = csr_bus.data[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         reserve_ff  <= RESERVE_RESET;
      end else begin
         capacity_ff <= capacity_in;
         reserve_ff  <= reserve_in;
      end
   end

   assign cfg.capacity = capacity_ff;
   assign cfg.reserve  = reserve_ff;

   sajf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   sajf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_bus)
   );

endmodule

`default_nettype wire

[sv/sajf_checker.sv]
`default_nettype none

module sajf_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [sajf_pkg::SAMPLE_W-1:0]   rsp_left_out,
   input  logic [sajf_pkg::SAMPLE_W-1:0]   rsp_right_out,
   input  logic                            rsp_silent,
   input  logic                            rsp_underrun_now,
   input  logic                            rsp_last_frame,
   input  logic [sajf_pkg::TOTAL_W-1:0]    rsp_overflow_total,
   input  logic [sajf_pkg::TOTAL_W-1:0]    rsp_underrun_total
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped during stall");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_left_out) && $stable(rsp_right_out) &&
         $stable(rsp_silent) && $stable(rsp_underrun_now) && $stable(rsp_last_frame) &&
         $stable(rsp_overflow_total) && $stable(rsp_underrun_total))
      else $error("rsp payload changed during stall");

   a_underrun_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_underrun_now |-> rsp_silent)
      else $error("underrun frame not silent");

   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_silent |-> rsp_left_out == '0 && rsp_right_out == '0)
      else $error("silent frame carries samples");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind stereo_audio_fifo_with_priming sajf_checker u_sajf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_left_out       (rsp_bus.left_out),
   .rsp_right_out      (rsp_bus.right_out),
   .rsp_silent         (rsp_bus.silent),
   .rsp_underrun_now   (rsp_bus.underrun_now),
   .rsp_last_frame     (rsp_bus.last_frame),
   .rsp_overflow_total (rsp_bus.overflow_total),
   .rsp_underrun_total (rsp_bus.underrun_total)
);

`default_nettype wire

[tb/sajf_tb_pkg.sv]
`timescale 1ns / 100ps

package sajf_tb_pkg;
   import sajf_pkg::*;

   typedef struct packed {
      logic [SAMPLE_W-1:0] left_smp;
      logic [SAMPLE_W-1:0] right_smp;
      logic                silent;
      logic                underrun;
      logic                last;
      logic [TOTAL_W-1:0]  overflow_total;
      logic [TOTAL_W-1:0]  underrun_total;
   } out_frame_type;

   class jitter_scoreboard;
      logic [FRAME_W-1:0] ring [STORE_DEPTH];
      int unsigned        rd_ptr;
      int unsigned        wr_ptr;
      int unsigned        fill;
      bit                 primed;
      logic [TOTAL_W-1:0] ovf_total;
      logic [TOTAL_W-1:0] und_total;
      logic [CFG_W-1:0]   capacity;
      logic [CFG_W-1:0]   reserve;
      out_frame_type      due_frames [$];
      int                 errors;

      function new();
         rd_ptr    = 0;
         wr_ptr    = 0;
         fill      = 0;
         primed    = 1'b0;
         ovf_total = '0;
         und_total = '0;
         capacity  = CAPACITY_RESET;
         reserve   = RESERVE_RESET;
         errors    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_CAPACITY) begin
            capacity = data[CFG_W-1:0];
         end else if (idx == CSR_RESERVE) begin
            reserve = data[CFG_W-1:0];
         end
      endfunction

      function void drop_oldest();
         rd_ptr    = (rd_ptr + 1) % STORE_DEPTH;
         fill      = fill - 1;
         ovf_total = ovf_total + 1;
      endfunction

      // one accepted command in, expected output frames appended
      function void apply_command(op_type op, logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r,
                                  logic [FRAME_COUNT_W-1:0] cnt);
         int unsigned        cap;
         int unsigned        req;
         bit                 mute;
         bit                 under;
         logic [FRAME_W-1:0] word;
         out_frame_type      f;
         mute  = 1'b0;
         under = 1'b0;
         if (op == OP_PUSH) begin
            cap = (capacity > STORE_DEPTH) ? STORE_DEPTH : capacity;
            if (fill >= STORE_DEPTH) begin
               drop_oldest();
            end
            ring[wr_ptr] = {r, l};
            wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
            fill = fill + 1;
            while (fill > cap) begin
               drop_oldest();
            end
         end else begin
            req = (cnt > MAX_TAKE) ? MAX_TAKE : cnt;
            if (!primed) begin
               if (fill < req + reserve) begin
                  mute = 1'b1;
               end else begin
                  primed = 1'b1;
               end
            end
            if (!mute && fill < req) begin
               und_total = und_total + 1;
               primed    = 1'b0;
               mute      = 1'b1;
               under     = 1'b1;
            end
            for (int k = 0; k < req; k++) begin
               word = '0;
               if (!mute) begin
                  word   = ring[rd_ptr];
                  rd_ptr = (rd_ptr + 1) % STORE_DEPTH;
                  fill   = fill - 1;
               end
               f.left_smp       = word[SAMPLE_W-1:0];
               f.right_smp      = word[FRAME_W-1:SAMPLE_W];
               f.silent         = mute;
               f.underrun       = under;
               f.last           = (k == req - 1);
               f.overflow_total = ovf_total;
               f.underrun_total = und_total;
               due_frames.insert(due_frames.size(), f);
            end
         end
      endfunction

      function void match(string what, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
         end
      endfunction

      function void check_frame(out_frame_type got);
         out_frame_type want;
         if (due_frames.size() == 0) begin
            errors++;
            $display("%0t: frame with none due, expected nothing actual %0h %0h",
                     $time, got.left_smp, got.right_smp);
         end else begin
            want = due_frames[0];
            due_frames.delete(0);
            match("left_out", want.left_smp, got.left_smp);
            match("right_out", want.right_smp, got.right_smp);
            match("silent", want.silent, got.silent);
            match("underrun_now", want.underrun, got.underrun);
            match("last_frame", want.last, got.last);
            match("overflow_total", want.overflow_total, got.overflow_total);
            match("underrun_total", want.underrun_total, got.underrun_total);
         end
      endfunction
   endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import sajf_pkg::*;
   import sajf_tb_pkg::*;

   localparam int MAX_CYCLES = 400000;
   localparam int LONG_HOLD  = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(15);

   logic        clock = 1'b0;
   logic        reset;
   logic        calm;
   int          hold_seq;
   int unsigned cycles;

   sajf_req_if req_bus();
   sajf_rsp_if rsp_bus();
   sajf_csr_if csr_bus();

   jitter_scoreboard sb = new();

   stereo_audio_fifo_with_priming dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #10 clock = ~clock;

   task automatic send_cmd(op_type op, logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r,
                           logic [FRAME_COUNT_W-1:0] cnt);
      while (!calm && $urandom_range(99) < 15) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.op           <= op;
      req_bus.left_sample  <= l;
      req_bus.right_sample <= r;
      req_bus.frame_count  <= cnt;
      do @(posedge clock); while (!req_bus.ready);
      sb.apply_command(op, l, r, cnt);
   endtask

   task automatic push_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
      send_cmd(OP_PUSH, l, r, FRAME_COUNT_W'($urandom));
   endtask

   task automatic take_frames(int cnt);
      send_cmd(OP_TAKE, $urandom, $urandom, FRAME_COUNT_W'(cnt));
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_reg(idx, data);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait out every due frame, then the pipe latency
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.due_frames.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic random_mix(int n);
      int pick;
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            push_frame($urandom, $urandom);
         end else if (pick < 80) begin
            take_frames($urandom_range(1, 8));
         end else if (pick < 90) begin
            take_frames($urandom_range(9, MAX_TAKE));
         end else if (pick < 95) begin
            take_frames(0);
         end else begin
            take_frames($urandom_range(MAX_TAKE + 1, 127));
         end
      end
   endtask

   initial begin : rsp_side
      int            hold_left;
      int            hold_seen;
      out_frame_type got;
      hold_left = 0;
      hold_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.left_out, rsp_bus.right_out, rsp_bus.silent,
                    rsp_bus.underrun_now, rsp_bus.last_frame,
                    rsp_bus.overflow_total, rsp_bus.underrun_total};
            sb.check_frame(got);
         end
         if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= 15);
         end
      end
   end

   initial begin : watchdog
      cycles = 0;
      while (cycles <= MAX_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_top: errors");
      $finish;
   end

   initial begin : stimulus
      reset                <= 1'b1;
      calm                 <= 1'b0;
      hold_seq             <= 0;
      req_bus.valid        <= 1'b0;
      req_bus.op           <= OP_PUSH;
      req_bus.left_sample  <= '0;
      req_bus.right_sample <= '0;
      req_bus.frame_count  <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= '0;
      csr_bus.data         <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: large reserve keeps it silent
      take_frames(4);
      push_frame(32'h8000_0000, 32'h7FFF_FFFF);
      push_frame(32'h7FFF_FFFF, 32'h8000_0000);
      take_frames(2);
      settle();

      // upper bits of the write are ignored; spare index does nothing
      csr_write(CSR_CAPACITY, 32'hFFFF_C006);
      csr_write(CSR_RESERVE, 32'd2);
      csr_write(CSR_SPARE, 32'hFFFF_FFFF);
      push_frame(32'h0000_0000, 32'hFFFF_FFFF);
      push_frame(32'hFFFF_FFFF, 32'h0000_0000);
      push_frame(32'h5555_5555, 32'hAAAA_AAAA);
      push_frame(32'hAAAA_AAAA, 32'h5555_5555);
      push_frame(32'h0000_0001, 32'h0000_0002);
      take_frames(3);
      take_frames(0);
      take_frames(3);
      take_frames(1);
      take_frames(127);
      push_frame($urandom, $urandom);
      push_frame($urandom, $urandom);
      take_frames(0);
      take_frames(MAX_TAKE + 1);
      settle();

      // zero capacity drops every push
      csr_write(CSR_CAPACITY, 32'd0);
      push_frame($urandom, $urandom);
      push_frame($urandom, $urandom);
      take_frames(1);
      settle();

      csr_write(CSR_CAPACITY, 32'd200);
      csr_write(CSR_RESERVE, 32'd4);
      random_mix(8);
      hold_seq <= hold_seq + 1;
      random_mix(22);
      calm <= 1'b1;
      random_mix(10);
      calm <= 1'b0;
      settle();

      // capacity above the store depth is saturated
      csr_write(CSR_CAPACITY, 32'h0000_3FFF);
      csr_write(CSR_RESERVE, 32'd0);
      calm <= 1'b1;
      repeat (10) push_frame($urandom, $urandom);
      take_frames(4);
      calm <= 1'b0;
      settle();

      // capacity below fill: next push trims it
      csr_write(CSR_CAPACITY, 32'd3);
      push_frame($urandom, $urandom);
      take_frames(2);
      random_mix(10);
      settle();

      csr_write(CSR_CAPACITY, 32'd8192);
      csr_write(CSR_RESERVE, 32'h0000_3FFF);
      repeat (10) push_frame($urandom, $urandom);
      take_frames(5);
      random_mix(5);
      settle();

      csr_write(CSR_CAPACITY, 32'd1);
      csr_write(CSR_RESERVE, 32'd1);
      random_mix(10);
      settle();

      if (sb.errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
